### hw/rtl/ssbm_pkg.sv
// shared types and constants for the stereo spectral bin multiplier
package ssbm_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned BIN_W    = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_APPLY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic [BIN_W-1:0]           bin_index;
    logic signed [SAMPLE_W-1:0] left_re;
    logic signed [SAMPLE_W-1:0] left_im;
    logic signed [SAMPLE_W-1:0] right_re;
    logic signed [SAMPLE_W-1:0] right_im;
  } in_word_t;

  typedef struct packed {
    logic [BIN_W-1:0]           out_bin;
    logic signed [SAMPLE_W-1:0] out_left_re;
    logic signed [SAMPLE_W-1:0] out_left_im;
    logic signed [SAMPLE_W-1:0] out_right_re;
    logic signed [SAMPLE_W-1:0] out_right_im;
    logic                       clipped;
    logic                       last_bin;
  } out_word_t;

  // load enables of the multiplier stages
  typedef struct packed {
    logic prod;
    logic sum;
    logic sat;
  } stage_en_t;

endpackage

### hw/rtl/stereo_spectral_bin_multiply_unit.sv
// stereo spectral bin multiplier top level: handshake, coefficient store, two complex multipliers
//
// Input channel (in_valid_i / in_stall_o / in_word_i) carries one word per bin.
// A load word (opcode load) writes the bin's left and right coefficients,
// saturated to COEF_FRAC_BITS+3 bits signed, and gives no result; a load to
// a bin above SPECTRAL_SIZE/2 is dropped. An apply word multiplies the bin's
// left and right complex samples by the stored coefficients and gives one
// result word on the output channel (out_valid_o / out_stall_i / out_word_o),
// rounded by COEF_FRAC_BITS bits and saturated to 24 bits. An apply to a bin
// out of range gives zero products. Applies may only read loaded bins.
// Throughput is one word per cycle, loads and applies in any mix, while the
// input is not stalled. A result passes the memory read, product, sum and
// saturation registers before it is valid. A load is visible to an apply
// accepted in the next cycle. When the receiver stalls, each stage holds and
// bubbles close up; the input stalls only once all four stages are full.
// Reset empties the pipeline; the coefficient memory is not cleared.
module stereo_spectral_bin_multiply_unit
  import ssbm_pkg::*;
#(
  parameter int unsigned SPECTRAL_SIZE  = 1024,
  parameter int unsigned COEF_FRAC_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned NUM_BINS = SPECTRAL_SIZE / 2 + 1;
  localparam int unsigned LAST_BIN = SPECTRAL_SIZE / 2;
  localparam int unsigned COEF_W   = COEF_FRAC_BITS + 3;
  localparam int unsigned ADDR_W   = $clog2(NUM_BINS);
  localparam int unsigned WORD_W   = 4 * COEF_W;

  logic      v1_q, v2_q, v3_q, v4_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;
  logic      in_accept, is_load, in_range, is_last;

  logic signed [SAMPLE_W-1:0] lre1_q, lim1_q, rre1_q, rim1_q;
  logic [BIN_W-1:0]           bin1_q, bin2_q, bin3_q, bin4_q;
  logic                       range1_q;
  logic                       last1_q, last2_q, last3_q, last4_q;

  logic [ADDR_W-1:0]        addr;
  logic [WORD_W-1:0]        rd_data, coef;
  logic signed [COEF_W-1:0] lc_re, lc_im, rc_re, rc_im;

  logic signed [SAMPLE_W-1:0] l_re, l_im, r_re, r_im;
  logic                       l_clip, r_clip;

  // each stage moves when it is empty or the next one moves
  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign en         = '{prod: rdy2, sum: rdy3, sat: rdy4};
  assign in_stall_o = !rdy1;
  assign in_accept  = in_valid_i && rdy1;

  assign is_load  = in_word_i.opcode == OP_LOAD;
  assign in_range = 32'(in_word_i.bin_index) < NUM_BINS;
  assign is_last  = 32'(in_word_i.bin_index) == LAST_BIN;
  assign addr     = ADDR_W'(in_word_i.bin_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_accept && !is_load;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lre1_q   <= in_word_i.left_re;
      lim1_q   <= in_word_i.left_im;
      rre1_q   <= in_word_i.right_re;
      rim1_q   <= in_word_i.right_im;
      bin1_q   <= in_word_i.bin_index;
      range1_q <= in_range;
      last1_q  <= is_last;
    end
    if (en.prod) begin
      bin2_q  <= bin1_q;
      last2_q <= last1_q;
    end
    if (en.sum) begin
      bin3_q  <= bin2_q;
      last3_q <= last2_q;
    end
    if (en.sat) begin
      bin4_q  <= bin3_q;
      last4_q <= last3_q;
    end
  end

  ssbm_coef_store #(
    .DEPTH  (NUM_BINS),
    .COEF_W (COEF_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && is_load && in_range),
    .wr_addr_i (addr),
    .wr_word_i (in_word_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (addr),
    .rd_data_o (rd_data)
  );

  // out-of-range bins multiply by zero
  assign coef  = range1_q ? rd_data : '0;
  assign lc_re = coef[3*COEF_W +: COEF_W];
  assign lc_im = coef[2*COEF_W +: COEF_W];
  assign rc_re = coef[1*COEF_W +: COEF_W];
  assign rc_im = coef[0 +: COEF_W];

  ssbm_cmul #(
    .COEF_W (COEF_W),
    .FRAC   (COEF_FRAC_BITS)
  ) u_cmul_left (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (lre1_q),
    .b_i    (lim1_q),
    .c_i    (lc_re),
    .d_i    (lc_im),
    .re_o   (l_re),
    .im_o   (l_im),
    .clip_o (l_clip)
  );

  ssbm_cmul #(
    .COEF_W (COEF_W),
    .FRAC   (COEF_FRAC_BITS)
  ) u_cmul_right (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (rre1_q),
    .b_i    (rim1_q),
    .c_i    (rc_re),
    .d_i    (rc_im),
    .re_o   (r_re),
    .im_o   (r_im),
    .clip_o (r_clip)
  );

  assign out_valid_o = v4_q;
  assign out_word_o  = '{
    out_bin:      bin4_q,
    out_left_re:  l_re,
    out_left_im:  l_im,
    out_right_re: r_re,
    out_right_im: r_im,
    clipped:      l_clip | r_clip,
    last_bin:     last4_q
  };

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with a free pipeline stage");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_load) |=> !v1_q)
    else $error("load word entered the result pipeline");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.clipped) |->
      (l_re == SAMPLE_MAX || l_re == SAMPLE_MIN || l_im == SAMPLE_MAX ||
       l_im == SAMPLE_MIN || r_re == SAMPLE_MAX || r_re == SAMPLE_MIN ||
       r_im == SAMPLE_MAX || r_im == SAMPLE_MIN))
    else $error("clip flag set without a saturated product");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.last_bin) |-> (32'(out_word_o.out_bin) == LAST_BIN))
    else $error("last bin mark on another bin");

  a_result_from_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v3_q))
    else $error("result appeared without an item in the sum stage");

endmodule

### hw/rtl/ssbm_coef_store.sv
// coefficient memory: saturates incoming coefficients, one write and one registered read port
module ssbm_coef_store
  import ssbm_pkg::*;
#(
  parameter int unsigned DEPTH  = 513,
  parameter int unsigned COEF_W = 18,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned WORD_W = 4 * COEF_W
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  in_word_t          wr_word_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  // lane 3 left re, lane 2 left im, lane 1 right re, lane 0 right im
  logic [4*SAMPLE_W-1:0] raw;
  logic [WORD_W-1:0]     wr_data;
  logic [WORD_W-1:0]     mem_q [DEPTH];
  logic [WORD_W-1:0]     rd_data_q;

  assign raw = {wr_word_i.left_re, wr_word_i.left_im, wr_word_i.right_re, wr_word_i.right_im};

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic signed [SAMPLE_W-1:0] x;
    assign x = raw[g*SAMPLE_W +: SAMPLE_W];
    if (COEF_W < SAMPLE_W) begin : g_clip
      logic ovf;
      assign ovf = x[SAMPLE_W-1:COEF_W-1] != {(SAMPLE_W-COEF_W+1){x[SAMPLE_W-1]}};
      assign wr_data[g*COEF_W +: COEF_W] =
          !ovf          ? x[COEF_W-1:0] :
          x[SAMPLE_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} :
                          {1'b0, {(COEF_W-1){1'b1}}};
    end else begin : g_ext
      assign wr_data[g*COEF_W +: COEF_W] = COEF_W'(x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/ssbm_cmul.sv
// three-stage complex multiplier: products, sums with rounding, shift and saturation
module ssbm_cmul
  import ssbm_pkg::*;
#(
  parameter int unsigned COEF_W = 18,
  parameter int unsigned FRAC   = 15
) (
  input  logic                       clk_i,
  input  stage_en_t                  en_i,
  input  logic signed [SAMPLE_W-1:0] a_i,
  input  logic signed [SAMPLE_W-1:0] b_i,
  input  logic signed [COEF_W-1:0]   c_i,
  input  logic signed [COEF_W-1:0]   d_i,
  output logic signed [SAMPLE_W-1:0] re_o,
  output logic signed [SAMPLE_W-1:0] im_o,
  output logic                       clip_o
);

  localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] RND =
      {{(SUM_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic signed [PROD_W-1:0]   ac_q, bd_q, bc_q, ad_q;
  logic signed [SUM_W-1:0]    re_sum_d, im_sum_d, re_sum_q, im_sum_q;
  logic signed [SUM_W-1:0]    re_sh, im_sh;
  logic [SAMPLE_W:0]          re_sat, im_sat;
  logic signed [SAMPLE_W-1:0] re_q, im_q;
  logic                       clip_q;

  // returns {hit, value}
  function automatic logic [SAMPLE_W:0] sat_fn(input logic signed [SUM_W-1:0] x);
    logic ovf;
    logic [SAMPLE_W:0] r;
    ovf = x[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){x[SUM_W-1]}};
    if (!ovf) begin
      r = {1'b0, x[SAMPLE_W-1:0]};
    end else if (x[SUM_W-1]) begin
      r = {1'b1, SAMPLE_MIN};
    end else begin
      r = {1'b1, SAMPLE_MAX};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      ac_q <= PROD_W'(a_i * c_i);
      bd_q <= PROD_W'(b_i * d_i);
      bc_q <= PROD_W'(b_i * c_i);
      ad_q <= PROD_W'(a_i * d_i);
    end
  end

  // round half up folded into the sum
  assign re_sum_d = SUM_W'(ac_q) - SUM_W'(bd_q) + RND;
  assign im_sum_d = SUM_W'(bc_q) + SUM_W'(ad_q) + RND;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      re_sum_q <= re_sum_d;
      im_sum_q <= im_sum_d;
    end
  end

  assign re_sh  = re_sum_q >>> FRAC;
  assign im_sh  = im_sum_q >>> FRAC;
  assign re_sat = sat_fn(re_sh);
  assign im_sat = sat_fn(im_sh);

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      re_q   <= re_sat[SAMPLE_W-1:0];
      im_q   <= im_sat[SAMPLE_W-1:0];
      clip_q <= re_sat[SAMPLE_W] | im_sat[SAMPLE_W];
    end
  end

  assign re_o   = re_q;
  assign im_o   = im_q;
  assign clip_o = clip_q;

endmodule
